@@ hdl/lrt_pkg.sv @@
// linear ramp table: shared types, command codes and sizes
// used by every module of the block but lrt_ram; depends on nothing
`default_nettype none

package lrt_pkg;

    localparam int LRT_MAX_RAMPS = 16;

    // command codes carried in tuser
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // kinds of result word loaded into the output register
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_ADD   = 2'd1;
    localparam logic [1:0] K_QUERY = 2'd2;
    localparam logic [1:0] K_TICK  = 2'd3;

    // product |end - start| * frame, and restoring divider length
    localparam int PROD_W = 49;
    localparam int STEP_W = 6;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        logic [7:0]         tag;
        logic [7:0]         target;
        logic signed [31:0] start_value;
        logic signed [31:0] end_value;
        logic [15:0]        total;
        logic [15:0]        frame;
    } t_ramp;

    typedef struct packed {
        logic       cap;
        logic       rd_idx;
        logic       rd_last;
        logic       wr_app;
        logic       wr_back;
        logic       wr_move;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       idx_inc;
        logic       ent_lat;
        logic       mul;
        logic       div_step;
        logic       flag_set;
        logic       out_ld;
        logic [1:0] out_kind;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       empty;
        logic       is_last;
        logic       done;
        logic       div_done;
        logic       match;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hdl/lrt_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module lrt_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/lrt_dp.sv @@
// linear ramp table datapath: ramp store, counters, multiplier, divider, output register
// depends on lrt_pkg and lrt_ram
`default_nettype none

module lrt_dp
    import lrt_pkg::*;
#(
    parameter int MAX_RAMPS = LRT_MAX_RAMPS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl                  i_ctl,
    output t_sts                       o_sts,
    input  wire logic [1:0]            i_command,
    input  wire logic [7:0]            i_tag,
    input  wire logic [7:0]            i_target,
    input  wire logic signed [31:0]    i_start_value,
    input  wire logic signed [31:0]    i_end_value,
    input  wire logic [15:0]           i_duration,
    input  wire logic [7:0]            i_query_tag_a,
    input  wire logic [7:0]            i_query_tag_b,
    input  wire logic                  i_query_use_b,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUT_DATA_W-1:0]      o_data,
    output logic                       o_last
);

    localparam int AW = (MAX_RAMPS > 1) ? $clog2(MAX_RAMPS) : 1;
    localparam int CW = $clog2(MAX_RAMPS + 1);

    logic [1:0]         r_cmd;
    t_ramp              r_new;
    logic [7:0]         r_qa;
    logic [7:0]         r_qb;
    logic               r_use_b;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic               r_flag;
    t_ramp              r_ent;
    logic               r_done;
    logic [PROD_W-1:0]  r_prod;
    logic [15:0]        r_rem;
    logic [STEP_W-1:0]  r_step;
    logic               r_neg;
    logic               r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic               r_olast;
    logic [OUT_DATA_W-1:0] n_odata;
    logic               n_olast;

    t_ramp              w_rdata;
    t_ramp              w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [AW-1:0]      w_waddr;
    logic [15:0]        w_frame;
    logic signed [32:0] w_diff;
    logic [32:0]        w_mag;
    logic [16:0]        w_trial;
    logic               w_ge;
    logic [31:0]        w_q;
    logic [31:0]        w_val;
    logic               w_is_last;

    assign w_raddr = i_ctl.rd_last ? AW'(r_count - CW'(1)) : r_idx;
    assign w_waddr = i_ctl.wr_app ? r_count[AW-1:0] : r_idx;

    always_comb begin
        w_wdata = r_ent;
        if (i_ctl.wr_app) begin
            w_wdata = r_new;
        end else if (i_ctl.wr_move) begin
            w_wdata = w_rdata;
        end
    end

    lrt_ram #(
        .W     ($bits(t_ramp)),
        .DEPTH (MAX_RAMPS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_app | i_ctl.wr_back | i_ctl.wr_move),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.rd_idx | i_ctl.rd_last),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // saturating frame advance
    assign w_frame = (w_rdata.frame == 16'hFFFF) ? w_rdata.frame : w_rdata.frame + 16'd1;

    assign w_diff = {r_ent.end_value[31], r_ent.end_value}
                  - {r_ent.start_value[31], r_ent.start_value};
    assign w_mag  = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);

    // one restoring step a cycle
    assign w_trial = {r_rem, r_prod[PROD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_ent.total};

    assign w_q   = r_prod[31:0];
    assign w_val = 32'(r_ent.start_value) + (r_neg ? 32'(-w_q) : w_q);

    assign w_is_last = (CW'(r_idx) + CW'(1)) == r_count;

    // next result word
    always_comb begin
        n_olast = 1'b1;
        n_odata = '0;
        case (i_ctl.out_kind)
            K_ADD: begin
                n_odata[42] = r_flag;
            end
            K_QUERY: begin
                n_odata[43] = r_flag;
            end
            K_TICK: begin
                n_odata[0]    = 1'b1;
                n_odata[8:1]  = r_ent.target;
                n_odata[40:9] = r_done ? 32'(r_ent.end_value) : w_val;
                n_odata[41]   = r_done;
                n_olast       = w_is_last;
            end
            default: begin
                n_olast = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_cmd   <= i_command;
            r_new   <= '{tag: i_tag, target: i_target, start_value: i_start_value,
                         end_value: i_end_value, total: i_duration, frame: 16'd0};
            r_qa    <= i_query_tag_a;
            r_qb    <= i_query_tag_b;
            r_use_b <= i_query_use_b;
        end
        if (i_ctl.ent_lat) begin
            r_ent  <= {w_rdata[$bits(t_ramp)-1:16], w_frame};
            r_done <= w_frame >= w_rdata.total;
        end
        if (i_ctl.mul) begin
            r_prod <= {16'd0, w_mag} * {33'd0, r_ent.frame};
            r_rem  <= 16'd0;
            r_step <= '0;
            r_neg  <= w_diff[32];
        end else if (i_ctl.div_step) begin
            r_rem  <= w_ge ? 16'(w_trial - {1'b0, r_ent.total}) : w_trial[15:0];
            r_prod <= {r_prod[PROD_W-2:0], w_ge};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_ctl.out_ld) begin
            r_odata <= n_odata;
            r_olast <= n_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctl.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_ctl.cap) begin
                r_idx  <= '0;
                r_flag <= 1'b0;
            end else begin
                if (i_ctl.idx_inc) begin
                    r_idx <= r_idx + AW'(1);
                end
                if (i_ctl.flag_set) begin
                    r_flag <= 1'b1;
                end
            end
            if (i_ctl.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.full     = r_count >= CW'(MAX_RAMPS);
        o_sts.empty    = r_count == '0;
        o_sts.is_last  = w_is_last;
        o_sts.done     = r_done;
        o_sts.div_done = r_step == STEP_W'(PROD_W - 1);
        o_sts.match    = (w_rdata.tag == r_qa) || (r_use_b && (w_rdata.tag == r_qb));
        o_sts.out_free = !r_ovalid || i_ready;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

@@ hdl/lrt_ctrl.sv @@
// linear ramp table controller: sequences add, tick and query over the datapath
// depends on lrt_pkg
`default_nettype none

module lrt_ctrl
    import lrt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_AEMIT = 4'd2;
    localparam logic [3:0] S_TRD   = 4'd3;
    localparam logic [3:0] S_TWAIT = 4'd4;
    localparam logic [3:0] S_TCHK  = 4'd5;
    localparam logic [3:0] S_TDIV  = 4'd6;
    localparam logic [3:0] S_TEMIT = 4'd7;
    localparam logic [3:0] S_MVRD  = 4'd8;
    localparam logic [3:0] S_MVWR  = 4'd9;
    localparam logic [3:0] S_QRD   = 4'd10;
    localparam logic [3:0] S_QCHK  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    CMD_ADD: begin
                        if (i_sts.full) begin
                            o_ctl.flag_set = 1'b1;
                        end else begin
                            o_ctl.wr_app  = 1'b1;
                            o_ctl.cnt_inc = 1'b1;
                        end
                        n_state = S_AEMIT;
                    end
                    CMD_TICK: begin
                        n_state = i_sts.empty ? S_AEMIT : S_TRD;
                    end
                    CMD_QUERY: begin
                        n_state = i_sts.empty ? S_AEMIT : S_QRD;
                    end
                    default: begin
                        n_state = S_AEMIT;
                    end
                endcase
            end
            S_AEMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_ld = 1'b1;
                    case (i_sts.cmd)
                        CMD_ADD:   o_ctl.out_kind = K_ADD;
                        CMD_QUERY: o_ctl.out_kind = K_QUERY;
                        default:   o_ctl.out_kind = K_NONE;
                    endcase
                    n_state = S_IDLE;
                end
            end
            S_TRD: begin
                o_ctl.rd_idx = 1'b1;
                n_state      = S_TWAIT;
            end
            S_TWAIT: begin
                o_ctl.ent_lat = 1'b1;
                n_state       = S_TCHK;
            end
            S_TCHK: begin
                if (i_sts.done) begin
                    n_state = S_TEMIT;
                end else begin
                    o_ctl.mul     = 1'b1;
                    o_ctl.wr_back = 1'b1;
                    n_state       = S_TDIV;
                end
            end
            S_TDIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_TEMIT;
                end
            end
            S_TEMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_ld   = 1'b1;
                    o_ctl.out_kind = K_TICK;
                    if (i_sts.done) begin
                        n_state = S_MVRD;
                    end else if (i_sts.is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.idx_inc = 1'b1;
                        n_state       = S_TRD;
                    end
                end
            end
            S_MVRD: begin
                o_ctl.rd_last = 1'b1;
                n_state       = S_MVWR;
            end
            S_MVWR: begin
                o_ctl.wr_move = 1'b1;
                o_ctl.cnt_dec = 1'b1;
                n_state       = i_sts.is_last ? S_IDLE : S_TRD;
            end
            S_QRD: begin
                o_ctl.rd_idx = 1'b1;
                n_state      = S_QCHK;
            end
            S_QCHK: begin
                if (i_sts.match) begin
                    o_ctl.flag_set = 1'b1;
                    n_state        = S_AEMIT;
                end else if (i_sts.is_last) begin
                    n_state = S_AEMIT;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = S_QRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/linear_ramp_table.sv @@
// linear ramp table: top level joining controller and datapath, with assertions
// depends on lrt_pkg, lrt_ctrl, lrt_dp (and lrt_ram below it)
`default_nettype none

// A table of up to MAX_RAMPS linear ramps in Q16.16. An add word (tuser 0)
// appends a ramp and answers with one word, status 1 if the table was full.
// A tick word (tuser 1) advances every ramp one frame and answers with one
// word per ramp carrying target and value start + (end-start)*frame/total,
// truncated toward zero; a finished ramp shows its end value with ramp_done
// set and is replaced by the last entry, which is handled next. A tick on an
// empty table answers with one word of zeros. A query word (tuser 2) answers
// with one word, found set when a ramp carries query_tag_a, or query_tag_b
// when query_use_b is set. tlast marks the final word of each answer. One
// input word is taken at a time. A tick on a running ramp is dominated by
// the 49-step restoring divider; any answer can be held by a stall on the
// output. The ramp store is one ram with a single write and a single
// registered read port.

module linear_ramp_table
    import lrt_pkg::*;
#(
    parameter int MAX_RAMPS = LRT_MAX_RAMPS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command word
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tag, target, start_value, end_value, duration, query_tag_a, query_tag_b,
    // query_use_b, zero padding
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  wire logic [1:0]            s_axis_tuser,
    // result word
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // write_valid, out_target, out_value, ramp_done, status, found, zero padding
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    t_ctl w_ctl;
    t_sts w_sts;

    // sequencer
    lrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // store, arithmetic and output register
    lrt_dp #(
        .MAX_RAMPS (MAX_RAMPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .i_command     (s_axis_tuser),
        .i_tag         (s_axis_tdata[7:0]),
        .i_target      (s_axis_tdata[15:8]),
        .i_start_value (s_axis_tdata[47:16]),
        .i_end_value   (s_axis_tdata[79:48]),
        .i_duration    (s_axis_tdata[95:80]),
        .i_query_tag_a (s_axis_tdata[103:96]),
        .i_query_tag_b (s_axis_tdata[111:104]),
        .i_query_use_b (s_axis_tdata[112]),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

    // a result word is only loaded when the output register can take it
    a_out_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.out_ld |-> w_sts.out_free)
        else $error("result loaded over an untaken word");

    // an append never goes past the table size
    a_no_overfill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.wr_app |-> !w_sts.full)
        else $error("append into a full table");

    // one command word at a time
    a_one_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while busy");

endmodule

`default_nettype wire

@@ dv/linear_ramp_table_tb.sv @@
// testbench for linear_ramp_table: directed table then random command words,
// every result word checked against a ramp table predictor; needs lrt_pkg
`default_nettype none

module linear_ramp_table_tb;
    import lrt_pkg::*;

    localparam int N_RAMPS = LRT_MAX_RAMPS;
    localparam int WATCHDOG_CYCLES = 20000;

    // one result word as seen on the master side
    typedef struct packed {
        logic               write_valid;
        logic [7:0]         out_target;
        logic signed [31:0] out_value;
        logic               ramp_done;
        logic               status;
        logic               found;
        logic               last;
    } t_word;

    // one input word
    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         tag;
        logic [7:0]         target;
        logic signed [31:0] start_value;
        logic signed [31:0] end_value;
        logic [15:0]        duration;
        logic [7:0]         qa;
        logic [7:0]         qb;
        logic               use_b;
    } t_cmd_word;

    // one directed row, with a typed expected word where it is obvious
    typedef struct packed {
        t_cmd_word c;
        logic      has_exp;
        t_word     exp_w;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    linear_ramp_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // predictor copy of the ramp store
    int unsigned         tbl_count;
    logic [7:0]          tbl_tag    [N_RAMPS];
    logic [7:0]          tbl_target [N_RAMPS];
    logic signed [31:0]  tbl_start  [N_RAMPS];
    logic signed [31:0]  tbl_end    [N_RAMPS];
    logic [15:0]         tbl_total  [N_RAMPS];
    logic [15:0]         tbl_frame  [N_RAMPS];

    t_word pending_words[$];
    int    n_errors = 0;
    int    n_dir_errors;
    int    n_words_seen = 0;
    int    n_cmds_sent;
    int    idle_src_pct;
    int    idle_snk_pct;
    int    quiet_cycles = 0;

    function automatic logic signed [31:0] interp(int unsigned k);
        logic signed [63:0] s, e, q;
        s = tbl_start[k];
        e = tbl_end[k];
        if (tbl_total[k] == 0 || tbl_frame[k] >= tbl_total[k])
            return tbl_end[k];
        q = ((e - s) * $signed({48'd0, tbl_frame[k]})) / $signed({48'd0, tbl_total[k]});
        return 32'(s + q);
    endfunction

    // works out the result words of one command and updates the copy
    task automatic predict_ramps(input t_cmd_word c);
        t_word       w;
        int unsigned k;
        int unsigned n;
        logic        hit;
        w = '0;
        case (c.cmd)
            CMD_ADD: begin
                if (tbl_count >= N_RAMPS) begin
                    w.status = 1'b1;
                end else begin
                    tbl_tag[tbl_count]    = c.tag;
                    tbl_target[tbl_count] = c.target;
                    tbl_start[tbl_count]  = c.start_value;
                    tbl_end[tbl_count]    = c.end_value;
                    tbl_total[tbl_count]  = c.duration;
                    tbl_frame[tbl_count]  = '0;
                    tbl_count++;
                end
                w.last = 1'b1;
                pending_words.push_back(w);
            end
            CMD_TICK: begin
                k = 0;
                n = 0;
                while (k < tbl_count && n < N_RAMPS) begin
                    if (tbl_frame[k] != 16'hffff)
                        tbl_frame[k]++;
                    w = '0;
                    w.write_valid = 1'b1;
                    w.out_target  = tbl_target[k];
                    w.out_value   = interp(k);
                    w.ramp_done   = tbl_frame[k] >= tbl_total[k];
                    n++;
                    if (w.ramp_done) begin
                        tbl_tag[k]    = tbl_tag[tbl_count-1];
                        tbl_target[k] = tbl_target[tbl_count-1];
                        tbl_start[k]  = tbl_start[tbl_count-1];
                        tbl_end[k]    = tbl_end[tbl_count-1];
                        tbl_total[k]  = tbl_total[tbl_count-1];
                        tbl_frame[k]  = tbl_frame[tbl_count-1];
                        tbl_count--;
                    end else begin
                        k++;
                    end
                    w.last = (n == N_RAMPS) || (k >= tbl_count);
                    pending_words.push_back(w);
                end
                if (n == 0) begin
                    w = '0;
                    w.last = 1'b1;
                    pending_words.push_back(w);
                end
            end
            default: begin
                hit = 1'b0;
                if (c.cmd == CMD_QUERY)
                    for (k = 0; k < tbl_count; k++)
                        if (tbl_tag[k] == c.qa || (c.use_b && tbl_tag[k] == c.qb))
                            hit = 1'b1;
                w.found = hit;
                w.last  = 1'b1;
                pending_words.push_back(w);
            end
        endcase
    endtask

    // drives one command word and waits for its acceptance
    task automatic send_word(input t_cmd_word c);
        while (idle_src_pct > 0 && $urandom_range(99) < idle_src_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.cmd;
        s_axis_tdata  <= {7'd0, c.use_b, c.qb, c.qa, c.duration, c.end_value,
                          c.start_value, c.target, c.tag};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_ramps(c);
        n_cmds_sent++;
        @(negedge i_clk);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= idle_snk_pct);
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_word got;
        t_word exp_w;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_CYCLES) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[40:9],
                       m_axis_tdata[41], m_axis_tdata[42], m_axis_tdata[43], m_axis_tlast};
                n_words_seen++;
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected word %h", $realtime, got);
                    n_errors++;
                end else begin
                    exp_w = pending_words.pop_front();
                    if (got !== exp_w || m_axis_tdata[47:44] !== 4'd0) begin
                        $display("%0t: mismatch expected %h actual %h (pad %h)",
                                 $realtime, exp_w, got, m_axis_tdata[47:44]);
                        n_errors++;
                    end
                end
            end
        end
    end

    function automatic t_cmd_word mk(input logic [1:0] cmd, input logic [7:0] tag,
                                     input logic [31:0] sv, input logic [31:0] ev,
                                     input logic [15:0] dur);
        t_cmd_word c;
        c = '0;
        c.cmd = cmd;
        c.tag = tag;
        c.target = ~tag;
        c.start_value = sv;
        c.end_value = ev;
        c.duration = dur;
        c.qa = tag;
        c.qb = ~tag;
        c.use_b = tag[0];
        return c;
    endfunction

    // row checked by the predictor only
    function automatic t_dir_row row_chk(input t_cmd_word c);
        t_dir_row r;
        r = '0;
        r.c = c;
        return r;
    endfunction

    // row with a single typed expected word
    function automatic t_dir_row row_exp(input t_cmd_word c, input logic st,
                                         input logic fd);
        t_dir_row r;
        r = '0;
        r.c = c;
        r.has_exp = 1'b1;
        r.exp_w.status = st;
        r.exp_w.found = fd;
        r.exp_w.last = 1'b1;
        return r;
    endfunction

    // random word: mostly short ramps so ticks finish them, few long ones
    function automatic t_cmd_word rand_word();
        t_cmd_word c;
        int        r;
        c = '0;
        r = $urandom_range(99);
        c.cmd = (r < 45) ? CMD_ADD : (r < 80) ? CMD_TICK : (r < 97) ? CMD_QUERY : 2'd3;
        c.tag = 8'($urandom_range(0, 7)) |
                (($urandom_range(9) == 0) ? 8'hf8 & 8'($urandom) : 8'd0);
        c.target = 8'($urandom);
        c.start_value = $urandom;
        c.end_value = $urandom;
        c.duration = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        c.qa = 8'($urandom_range(0, 9));
        c.qb = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
        c.use_b = 1'($urandom);
        return c;
    endfunction

    task automatic run_random(input int n_words);
        for (int i = 0; i < n_words; i++)
            send_word(rand_word());
    endtask

    // directed rows; expected words only where obvious, others go to predictor
    t_dir_row  dir_rows[$];
    t_word     dir_last;
    int        guard;

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_src_pct  = 0;
        idle_snk_pct  = 0;
        n_dir_errors  = 0;
        n_cmds_sent   = 0;
        tbl_count     = 0;
        i_rst_n       = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // tick on empty table, unused command, query on empty table
        dir_rows.push_back(row_exp(mk(CMD_TICK, 8'h00, 32'd0, 32'd0, 16'd0), 1'b0, 1'b0));
        dir_rows.push_back(row_exp(mk(2'd3, 8'hff, 32'hffffffff, 32'hffffffff, 16'hffff),
                                   1'b0, 1'b0));
        dir_rows.push_back(row_exp(mk(CMD_QUERY, 8'h11, 32'd0, 32'd0, 16'd0), 1'b0, 1'b0));
        // extremes of start and end, zero and maximum durations
        dir_rows.push_back(row_chk(mk(CMD_ADD, 8'h00, 32'h80000000, 32'h7fffffff, 16'd3)));
        dir_rows.push_back(row_chk(mk(CMD_ADD, 8'hff, 32'h7fffffff, 32'h80000000, 16'hffff)));
        dir_rows.push_back(row_chk(mk(CMD_ADD, 8'h5a, 32'h00010000, 32'hffff0000, 16'd0)));
        dir_rows.push_back(row_chk(mk(CMD_ADD, 8'ha5, 32'hfffffffd, 32'h00000004, 16'd1)));
        dir_rows.push_back(row_chk(mk(CMD_QUERY, 8'h5a, 32'd0, 32'd0, 16'd0)));
        dir_rows.push_back(row_chk(mk(CMD_QUERY, 8'h01, 32'd0, 32'd0, 16'd0)));
        dir_rows.push_back(row_chk(mk(CMD_TICK, 8'h00, 32'd0, 32'd0, 16'd0)));
        dir_rows.push_back(row_chk(mk(CMD_TICK, 8'h00, 32'd0, 32'd0, 16'd0)));
        dir_rows.push_back(row_chk(mk(CMD_QUERY, 8'h5a, 32'd0, 32'd0, 16'd0)));
        // fill the table past full so the last adds are refused
        for (int i = 0; i < 16; i++) begin
            if (i < 14)
                dir_rows.push_back(row_chk(mk(CMD_ADD, 8'(i), 32'($urandom),
                                              32'($urandom), 16'(i % 4))));
            else
                dir_rows.push_back(row_exp(mk(CMD_ADD, 8'(i), 32'($urandom),
                                              32'($urandom), 16'(i % 4)), 1'b1, 1'b0));
        end
        dir_rows.push_back(row_chk(mk(CMD_TICK, 8'h00, 32'd0, 32'd0, 16'd0)));
        dir_rows.push_back(row_chk(mk(CMD_TICK, 8'h00, 32'd0, 32'd0, 16'd0)));

        idle_src_pct = 23;
        idle_snk_pct = 65;
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].c);
            if (dir_rows[i].has_exp) begin
                dir_last = (pending_words.size() == 0) ? 'x
                           : pending_words[pending_words.size() - 1];
                if (dir_last !== dir_rows[i].exp_w) begin
                    $display("%0t: mismatch expected %h actual %h (directed row %0d)",
                             $realtime, dir_rows[i].exp_w, dir_last, i);
                    n_dir_errors++;
                end
            end
        end
        run_random(80);
        idle_src_pct = 65;
        idle_snk_pct = 23;
        run_random(80);
        idle_src_pct = 0;
        idle_snk_pct = 0;
        run_random(80);
        // tick the table on so the short ramps are seen finishing
        for (int i = 0; i < 8; i++)
            send_word(mk(CMD_TICK, 8'h00, 32'd0, 32'd0, 16'd0));
        s_axis_tvalid <= 1'b0;

        guard = 0;
        while (pending_words.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $realtime,
                     pending_words.size());
            n_dir_errors++;
        end
        $display("%0d command words sent, %0d result words checked, %0d errors",
                 n_cmds_sent, n_words_seen, n_errors + n_dir_errors);
        if (n_errors + n_dir_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ linear_ramp_table.f @@
hdl/lrt_pkg.sv
hdl/lrt_ram.sv
hdl/lrt_dp.sv
hdl/lrt_ctrl.sv
hdl/linear_ramp_table.sv
dv/linear_ramp_table_tb.sv
